FILE: rtl/core/kmp_pkg.sv
// shared types and constants for the kmp substring search block
// no dependencies
package kmp_pkg;

  localparam int PATTERN_MAX_DEF = 128;
  localparam int INDEX_BITS_DEF  = 16;

  // item kinds carried in s_tuser[0]
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEXT = 1'b1;

  localparam int START_BITS = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_WRAP,
    S_OUT
  } kmp_state_t;

endpackage

FILE: rtl/core/kmp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/kmp_substring_search_top.sv
// streaming knuth-morris-pratt matcher: pattern load with incremental failure table, text search
// depends on kmp_pkg and kmp_ram
//
// channel   dir  width  contents
// s_tdata   in   8      data_byte
// s_tuser   in   2      action, first
// m_tdata   out  24     match, match_start[15:0], search_done, pattern_overflow, zero fill
//
// one item at a time; s_tready is high only while the sequencer is idle
// pattern byte: idle, step (again per failure-table fallback step), out; only idle, out for
//   the first byte or a drop. text byte: idle, step (again per fallback step), wrap on a full
//   match, out; only idle, out once the search is done or with an empty pattern
// each fallback step is one read of the pattern store and failure table rams
// reset clears lengths, border, search state and the output valid; ram contents are not cleared
// a stalled m_tready holds the result; the next item is accepted while it waits
module kmp_substring_search_top
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [0] action, [1] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] match, [16:1] match_start, [17] search_done,
                                 // [18] pattern_overflow, [23:19] zero
);

  localparam int LB = $clog2(PATTERN_MAX);      // border / store index width
  localparam int LW = $clog2(PATTERN_MAX + 1);  // length / table index width
  localparam int IB = INDEX_BITS;

  kmp_state_t state, state_next;

  logic [LW-1:0] len, len_next;
  logic [LB-1:0] bp, bp_next;
  logic [LB-1:0] mc, mc_next;
  logic [IB-1:0] ti, ti_next;
  logic          found, found_next;
  logic          m_tvalid_next;

  logic          kind, kind_next;
  logic [7:0]    cur_byte, cur_byte_next;
  logic [LB-1:0] j, j_next;
  logic          res_match, res_match_next;
  logic [START_BITS-1:0] res_start, res_start_next;
  logic          res_ovf, res_ovf_next;
  logic          out_load;

  logic          store_we;
  logic [LB-1:0] store_wa;
  logic [7:0]    store_rd;
  logic          ft_we;
  logic [LW-1:0] ft_wa;
  logic [LB-1:0] ft_wd;
  logic [LB-1:0] ft_rd;
  logic [LB-1:0] rd_j;
  logic          rd_len_sel;
  logic [LW-1:0] ft_ra;

  logic          item_action;
  logic          item_first;
  logic [LW-1:0] len_eff;
  logic [LB-1:0] mc_eff;
  logic [IB-1:0] ti_eff;
  logic          found_eff;
  logic          hit;
  logic [LW-1:0] j_new;
  logic          sat;

  assign item_action = s_tuser[0];
  assign item_first  = s_tuser[1];
  assign ft_ra       = rd_len_sel ? len : LW'(rd_j);

  kmp_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (store_wa),
    .wr_data (cur_byte_next),
    .rd_addr (rd_j),
    .rd_data (store_rd)
  );

  kmp_ram #(.WIDTH(LB), .DEPTH(PATTERN_MAX + 1)) u_fail (
    .clk     (clk),
    .wr_en   (ft_we),
    .wr_addr (ft_wa),
    .wr_data (ft_wd),
    .rd_addr (ft_ra),
    .rd_data (ft_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    len_next       = len;
    bp_next        = bp;
    mc_next        = mc;
    ti_next        = ti;
    found_next     = found;
    kind_next      = kind;
    cur_byte_next  = cur_byte;
    j_next         = j;
    res_match_next = res_match;
    res_start_next = res_start;
    res_ovf_next   = res_ovf;
    out_load       = 1'b0;
    store_we       = 1'b0;
    store_wa       = len[LB-1:0];
    ft_we          = 1'b0;
    ft_wa          = len + LW'(1);
    ft_wd          = '0;
    rd_j           = j;
    rd_len_sel     = 1'b0;
    s_tready       = 1'b0;

    // a first flag restarts the text search for either kind of item
    len_eff   = (item_action == ACT_LOAD && item_first) ? '0 : len;
    mc_eff    = item_first ? '0 : mc;
    ti_eff    = item_first ? '0 : ti;
    found_eff = item_first ? 1'b0 : found;

    hit   = (store_rd == cur_byte);
    j_new = LW'(j) + LW'(hit);
    sat   = (state == S_IDLE) ? (ti_eff == '1) : (ti == '1);

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          kind_next      = item_action;
          cur_byte_next  = s_tdata;
          res_match_next = 1'b0;
          res_start_next = '0;
          res_ovf_next   = 1'b0;
          mc_next        = mc_eff;
          ti_next        = ti_eff;
          found_next     = found_eff;
          len_next       = len_eff;
          if (item_action == ACT_LOAD && item_first) begin
            bp_next = '0;
          end
          if (item_action == ACT_LOAD) begin
            if (len_eff == LW'(PATTERN_MAX)) begin
              res_ovf_next = 1'b1;
              state_next   = S_OUT;
            end else begin
              store_we = 1'b1;
              store_wa = len_eff[LB-1:0];
              if (len_eff == '0) begin
                ft_we      = 1'b1;
                ft_wa      = LW'(1);
                ft_wd      = '0;
                len_next   = LW'(1);
                bp_next    = '0;
                state_next = S_OUT;
              end else begin
                j_next     = bp;
                rd_j       = bp;
                state_next = S_STEP;
              end
            end
          end else begin
            if (found_eff) begin
              state_next = S_OUT;
            end else if (len == '0) begin
              if (!sat) begin
                ti_next = ti_eff + IB'(1);
              end
              state_next = S_OUT;
            end else begin
              j_next     = mc_eff;
              rd_j       = mc_eff;
              state_next = S_STEP;
            end
          end
        end
      end
      S_STEP: begin
        if (j != '0 && !hit) begin
          // fall back along the failure table, read issued straight from ram output
          j_next = ft_rd;
          rd_j   = ft_rd;
        end else if (kind == ACT_LOAD) begin
          ft_we      = 1'b1;
          ft_wa      = len + LW'(1);
          ft_wd      = j_new[LB-1:0];
          bp_next    = j_new[LB-1:0];
          len_next   = len + LW'(1);
          state_next = S_OUT;
        end else begin
          if (!sat) begin
            ti_next = ti + IB'(1);
          end
          if (j_new == len) begin
            if (!sat) begin
              res_match_next = 1'b1;
              res_start_next = START_BITS'(ti - IB'(len) + IB'(1));
              found_next     = 1'b1;
            end
            rd_len_sel = 1'b1;
            state_next = S_WRAP;
          end else begin
            mc_next    = j_new[LB-1:0];
            state_next = S_OUT;
          end
        end
      end
      S_WRAP: begin
        mc_next    = ft_rd;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      bp       <= '0;
      mc       <= '0;
      ti       <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      len      <= len_next;
      bp       <= bp_next;
      mc       <= mc_next;
      ti       <= ti_next;
      found    <= found_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind      <= kind_next;
    cur_byte  <= cur_byte_next;
    j         <= j_next;
    res_match <= res_match_next;
    res_start <= res_start_next;
    res_ovf   <= res_ovf_next;
    if (out_load) begin
      m_tdata <= {5'b0, res_ovf, found, res_start, res_match};
    end
  end

  // matched count stays below the pattern length
  a_mc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (mc == '0 || LW'(mc) < len))
    else $error("matched count not below pattern length");

  // stored border is a proper border
  a_bp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && len != '0) |-> (LW'(bp) < len))
    else $error("border not shorter than pattern");

  // each fallback step shortens the border
  a_fall_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && $past(state) == S_STEP) |-> (j < $past(j)))
    else $error("fallback did not shorten the border");

  // a reported match always comes with search_done
  a_match_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[0] || m_tdata[17]))
    else $error("match without search_done");

endmodule
